FILE: design/tns_pkg.sv
// shared types, constants and arithmetic helpers of the tns all-pole filter
`default_nettype none

package tns_pkg;

  localparam int CoefTaps     = 20;
  localparam int NumCoefWords = 5;
  localparam int CoefFlatW    = NumCoefWords * 64;

  typedef enum logic [2:0] {
    REG_FILTER_ORDER   = 3'd0,
    REG_STATE_SHIFT    = 3'd1,
    REG_HEADROOM_SHIFT = 3'd2,
    REG_COEF_A         = 3'd3,
    REG_COEF_B         = 3'd4,
    REG_COEF_C         = 3'd5,
    REG_COEF_D         = 3'd6,
    REG_COEF_E         = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic load;
    logic tap_valid;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // taps packed four to a word, tap one in the lowest 16 bits
  function automatic logic signed [15:0] coef_of(input logic [CoefFlatW-1:0] flat,
                                                 input logic [4:0] idx);
    logic signed [15:0] c;
    if (idx >= 5'(CoefTaps)) begin
      c = '0;
    end else begin
      c = flat[{idx, 4'b0000} +: 16];
    end
    return c;
  endfunction

  // positive amount saturates left, negative shifts right arithmetically
  function automatic logic signed [31:0] dir_shift(input logic signed [31:0] y,
                                                   input logic signed [5:0] s);
    logic [5:0]         neg;
    logic [4:0]         amt;
    logic signed [63:0] wide;
    logic signed [31:0] r;
    neg  = 6'(-s);
    wide = 64'(y);
    if (s[5]) begin
      amt = neg[5] ? 5'd31 : neg[4:0];
      r   = y >>> amt;
    end else begin
      amt  = s[4:0];
      wide = wide <<< amt;
      r    = sat32(wide);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/tns_cell.sv
// one delay line cell: holds one stored sample, takes its neighbor's on shift
`default_nettype none

module tns_cell
  import tns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctl_t         ctl,
  input  wire logic signed [31:0] d_in,
  output logic signed [31:0]     d_out
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      d_out <= '0;
    end else if (ctl.shift) begin
      d_out <= d_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/tns_tap_mac.sv
// shared tap unit: registered q15 product, then saturating subtract into y
`default_nettype none

module tns_tap_mac
  import tns_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mac_ctl_t           ctl,
  input  wire logic signed [31:0] y_init,
  input  wire logic signed [31:0] tap,
  input  wire logic signed [15:0] coef,
  output logic signed [31:0]      y
);

  logic signed [47:0] prod;
  logic               special;
  logic               prod_valid;
  logic signed [31:0] p;
  logic signed [63:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= 48'(tap) * 48'(coef);
    // most negative sample times most negative coef overflows the doubling
    special <= (tap == 32'sh80000000) && (coef == 16'sh8000);
  end

  always_comb begin
    p    = special ? 32'sh7fffffff : $signed({prod[46:16], 1'b0});
    diff = 64'(y) - 64'(p);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      y <= y_init;
    end else if (prod_valid) begin
      y <= sat32(diff);
    end
  end

endmodule

`default_nettype wire

FILE: design/tns_all_pole_filter.sv
// top level of the tns all-pole filter: config registers, sequencer, cell chain
`default_nettype none

// Temporal noise shaping all-pole filter. Each sample is shifted left by
// headroom_shift (wrapping), then filter_order taps (at most 20 and at most
// MAX_TAPS) are subtracted with saturation, highest tap first; the result goes
// back into the delay line through the state shift and leaves shifted right by
// headroom_shift. The delay line is a ring of MAX_TAPS cells that turns once per
// sample, presenting one stored value a cycle to a single shared
// multiply-subtract unit; every sample runs a full turn whatever the order,
// then a drain state and a final state that waits for the output register
// to free up. A set tuser bit starts a new block and clears the delay line in
// the cycle the sample is taken. Configuration is to be written only while
// no sample is in flight: a rule for the user that the block does not enforce.
module tns_all_pole_filter
  import tns_pkg::*;
#(
  parameter int MAX_TAPS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input samples
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic        s_tuser,   // [0] block_start
  // filtered samples
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] filtered_sample
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [KW-1:0] KLast = KW'(MAX_TAPS - 1);
  localparam logic [5:0] MaxTapsW = 6'(MAX_TAPS);
  localparam int OrdLimit = (MAX_TAPS < CoefTaps) ? MAX_TAPS : CoefTaps;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

  state_t             state;
  logic [KW-1:0]      k;
  logic [4:0]         filter_order;
  logic signed [5:0]  state_shift;
  logic [4:0]         headroom_shift;
  logic [63:0]        coef_word [NumCoefWords];
  logic [CoefFlatW-1:0] coef_flat;

  logic [4:0]         ord;
  logic [5:0]         j;
  logic [5:0]         j_m1;
  logic               tap_active;
  logic               lookahead;
  logic               s_acc;
  logic               fin_write;
  logic signed [31:0] cell_q [MAX_TAPS];
  logic signed [31:0] feed;
  logic signed [31:0] cell0_in;
  logic signed [31:0] y_init;
  logic signed [31:0] y;
  logic signed [15:0] coef;
  cell_ctl_t          ctl_first;
  cell_ctl_t          ctl_rest;
  mac_ctl_t           mac_ctl;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order   <= '0;
      state_shift    <= '0;
      headroom_shift <= '0;
      for (int i = 0; i < NumCoefWords; i++) begin
        coef_word[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_FILTER_ORDER:   filter_order   <= cfg_data[4:0];
        REG_STATE_SHIFT:    state_shift    <= cfg_data[5:0];
        REG_HEADROOM_SHIFT: headroom_shift <= cfg_data[4:0];
        REG_COEF_A:         coef_word[0]   <= cfg_data;
        REG_COEF_B:         coef_word[1]   <= cfg_data;
        REG_COEF_C:         coef_word[2]   <= cfg_data;
        REG_COEF_D:         coef_word[3]   <= cfg_data;
        REG_COEF_E:         coef_word[4]   <= cfg_data;
        default:            filter_order   <= filter_order;
      endcase
    end
  end

  always_comb begin
    coef_flat = {coef_word[4], coef_word[3], coef_word[2], coef_word[1], coef_word[0]};
    ord = (filter_order > 5'(OrdLimit)) ? 5'(OrdLimit) : filter_order;
    // the top cell holds tap j's history value at step k
    j    = MaxTapsW - 6'(k);
    j_m1 = j - 6'd1;
    tap_active = (state == ST_RUN) && (j <= {1'b0, ord});
    // cells one to ord take their lower neighbor, so feed one step ahead
    lookahead = (j <= ({1'b0, ord} + 6'd1)) && (k != KLast);
    coef   = coef_of(coef_flat, j_m1[4:0]);
    s_acc  = s_tvalid && s_tready;
    y_init = $signed(s_tdata << headroom_shift);
    fin_write = (state == ST_FIN) && (!m_tvalid || m_tready);
  end

  assign s_tready = (state == ST_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !fin_write) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          k <= k + KW'(1);
          if (k == KLast) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_write) begin
            m_tvalid <= 1'b1;
            m_tdata  <= y >>> headroom_shift;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ring of delay cells
  generate
    if (MAX_TAPS > 1) begin : g_feed
      assign feed = lookahead ? cell_q[MAX_TAPS-2] : cell_q[MAX_TAPS-1];
    end else begin : g_feed_single
      assign feed = cell_q[MAX_TAPS-1];
    end
  endgenerate

  always_comb begin
    cell0_in        = (state == ST_FIN) ? dir_shift(y, state_shift) : feed;
    ctl_rest.clr    = s_acc && s_tuser;
    ctl_rest.shift  = (state == ST_RUN);
    ctl_first.clr   = ctl_rest.clr;
    ctl_first.shift = (state == ST_RUN) || fin_write;
    mac_ctl.load      = s_acc;
    mac_ctl.tap_valid = tap_active;
  end

  generate
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cells
      if (i == 0) begin : g_first
        tns_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctl   (ctl_first),
          .d_in  (cell0_in),
          .d_out (cell_q[i])
        );
      end else begin : g_rest
        tns_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .ctl   (ctl_rest),
          .d_in  (cell_q[i-1]),
          .d_out (cell_q[i])
        );
      end
    end
  endgenerate

  tns_tap_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .y_init (y_init),
    .tap    (cell_q[MAX_TAPS-1]),
    .coef   (coef),
    .y      (y)
  );

  // an accepted transaction starts a fresh turn of the ring
  a_start_turn: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (state == ST_RUN) && (k == '0))
    else $error("accepted sample did not start at step zero");

  // a result appears only from the final state of a turn
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside the final state");

  // no tap is used beyond the clamped order
  a_order_clamp: assert property (@(posedge clk) disable iff (rst)
    tap_active |-> (j != 6'd0) && (j <= 6'(OrdLimit)))
    else $error("tap beyond clamped order was used");

endmodule

`default_nettype wire
